### hdl/hbp_pkg.sv
// Shared types and constants of the header block parser.
`timescale 1ns / 1ps

package hbp_pkg;

  // The most results one input item may cause; it also caps the key buffer.
  localparam int unsigned MaxResults = 32;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;

  typedef enum logic [2:0] {
    PS_INITIAL = 3'd0,
    PS_KEY     = 3'd1,
    PS_VALUE   = 3'd2,
    PS_NEWLINE = 3'd3,
    PS_ERROR   = 3'd4,
    PS_FINAL   = 3'd5
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_HDR_END = 2'd2,
    KIND_BLK_END = 2'd3
  } out_kind_e;

  // What an accepted item asks of the controller.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ONE  = 2'd1,
    ACT_TWO  = 2'd2,
    ACT_KEYS = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CS_IDLE    = 3'd0,
    CS_OUT     = 3'd1,
    CS_HDR_OUT = 3'd2,
    CS_KEY_RD  = 3'd3,
    CS_KEY_OUT = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic load_blk;
    logic key_rd;
  } dp_cmd_t;

  typedef struct packed {
    action_e act;
    logic    out_last;
  } dp_status_t;

endpackage

### hdl/hbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/hbp_datapath.sv
// Datapath of the header block parser: parse state, flags, key buffer and result register.
`timescale 1ns / 1ps

module hbp_datapath #(
  parameter int unsigned KeyCap = 32,
  localparam int unsigned CntW  = $clog2(KeyCap + 1),
  localparam int unsigned AddrW = (KeyCap > 1) ? $clog2(KeyCap) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           data_byte_i,
  input  hbp_pkg::dp_cmd_t     cmd_i,
  output hbp_pkg::dp_status_t  status_o,
  output logic [1:0]           out_kind_o,
  output logic [7:0]           out_byte_o,
  output logic                 last_o,
  output logic                 had_errors_o,
  output logic                 had_folding_o,
  output logic                 key_overflow_o
);

  hbp_pkg::parse_state_e ps_q, ps_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             vs_q, vs_d;
  logic             err_q, err_d;
  logic             fold_q, fold_d;
  logic             ovf_q, ovf_d;
  logic [CntW-1:0]  len_q;
  logic [AddrW-1:0] idx_q;

  hbp_pkg::action_e   act;
  hbp_pkg::out_kind_e res_kind;
  logic [7:0]         res_byte;
  logic               store;
  logic               store_fresh;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic               key_last;

  hbp_pkg::out_kind_e kind_q;
  logic [7:0]         byte_q;
  logic               last_q;
  logic               from_ram_q;
  logic               oerr_q, ofold_q, oovf_q;
  logic [7:0]         ram_rdata;

  // Decode of one byte against the parse state.
  always_comb begin
    logic [CntW-1:0] base;
    ps_d        = ps_q;
    cnt_d       = cnt_q;
    vs_d        = vs_q;
    err_d       = err_q;
    fold_d      = fold_q;
    ovf_d       = ovf_q;
    act         = hbp_pkg::ACT_NONE;
    res_kind    = hbp_pkg::KIND_VALUE;
    res_byte    = data_byte_i;
    store       = 1'b0;
    store_fresh = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    base        = '0;
    if (ps_q inside {hbp_pkg::PS_INITIAL, hbp_pkg::PS_KEY, hbp_pkg::PS_VALUE,
                     hbp_pkg::PS_NEWLINE, hbp_pkg::PS_ERROR}) begin
      case (data_byte_i)
        hbp_pkg::ChNul: begin
          err_d = 1'b1;
        end
        hbp_pkg::ChCr: begin
        end
        hbp_pkg::ChLf: begin
          case (ps_q)
            hbp_pkg::PS_INITIAL: begin
              act      = hbp_pkg::ACT_ONE;
              res_kind = hbp_pkg::KIND_BLK_END;
              res_byte = '0;
              ps_d     = hbp_pkg::PS_FINAL;
            end
            hbp_pkg::PS_KEY: begin
              err_d = 1'b1;
              cnt_d = '0;
              ps_d  = hbp_pkg::PS_INITIAL;
            end
            hbp_pkg::PS_VALUE: begin
              ps_d = hbp_pkg::PS_NEWLINE;
            end
            hbp_pkg::PS_NEWLINE: begin
              act      = hbp_pkg::ACT_TWO;
              res_kind = hbp_pkg::KIND_HDR_END;
              res_byte = '0;
              cnt_d    = '0;
              vs_d     = 1'b0;
              ps_d     = hbp_pkg::PS_FINAL;
            end
            default: begin
              cnt_d = '0;
              ps_d  = hbp_pkg::PS_INITIAL;
            end
          endcase
        end
        hbp_pkg::ChSpace, hbp_pkg::ChTab: begin
          case (ps_q)
            hbp_pkg::PS_INITIAL, hbp_pkg::PS_KEY: begin
              cnt_d = '0;
              err_d = 1'b1;
              ps_d  = hbp_pkg::PS_ERROR;
            end
            hbp_pkg::PS_VALUE: begin
              if (vs_q) begin
                act = hbp_pkg::ACT_ONE;
              end
            end
            hbp_pkg::PS_NEWLINE: begin
              fold_d = 1'b1;
              ps_d   = hbp_pkg::PS_VALUE;
              if (vs_q) begin
                act = hbp_pkg::ACT_ONE;
              end
            end
            default: begin
            end
          endcase
        end
        hbp_pkg::ChColon: begin
          case (ps_q)
            hbp_pkg::PS_INITIAL: begin
              err_d = 1'b1;
              ps_d  = hbp_pkg::PS_ERROR;
            end
            hbp_pkg::PS_KEY: begin
              if (cnt_q != '0) begin
                act = hbp_pkg::ACT_KEYS;
              end
              cnt_d = '0;
              vs_d  = 1'b0;
              ps_d  = hbp_pkg::PS_VALUE;
            end
            hbp_pkg::PS_VALUE: begin
              act  = hbp_pkg::ACT_ONE;
              vs_d = 1'b1;
            end
            hbp_pkg::PS_NEWLINE: begin
              // The header end goes out before the error flag is raised.
              act      = hbp_pkg::ACT_ONE;
              res_kind = hbp_pkg::KIND_HDR_END;
              res_byte = '0;
              cnt_d    = '0;
              vs_d     = 1'b0;
              err_d    = 1'b1;
              ps_d     = hbp_pkg::PS_ERROR;
            end
            default: begin
            end
          endcase
        end
        default: begin
          case (ps_q)
            hbp_pkg::PS_INITIAL: begin
              store = 1'b1;
              ps_d  = hbp_pkg::PS_KEY;
            end
            hbp_pkg::PS_KEY: begin
              store = 1'b1;
            end
            hbp_pkg::PS_VALUE: begin
              act  = hbp_pkg::ACT_ONE;
              vs_d = 1'b1;
            end
            hbp_pkg::PS_NEWLINE: begin
              act         = hbp_pkg::ACT_ONE;
              res_kind    = hbp_pkg::KIND_HDR_END;
              res_byte    = '0;
              vs_d        = 1'b0;
              store       = 1'b1;
              store_fresh = 1'b1;
              ps_d        = hbp_pkg::PS_KEY;
            end
            default: begin
            end
          endcase
        end
      endcase
    end
    if (store) begin
      base = store_fresh ? '0 : cnt_q;
      if (base < CntW'(KeyCap)) begin
        wr_en   = 1'b1;
        wr_addr = base[AddrW-1:0];
        cnt_d   = base + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign key_last = ((CntW'(idx_q) + CntW'(1)) == len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q   <= hbp_pkg::PS_INITIAL;
      cnt_q  <= '0;
      vs_q   <= 1'b0;
      err_q  <= 1'b0;
      fold_q <= 1'b0;
      ovf_q  <= 1'b0;
      len_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.take) begin
        ps_q   <= ps_d;
        cnt_q  <= cnt_d;
        vs_q   <= vs_d;
        err_q  <= err_d;
        fold_q <= fold_d;
        ovf_q  <= ovf_d;
        if (act == hbp_pkg::ACT_KEYS) begin
          len_q <= cnt_q;
          idx_q <= '0;
        end
      end else if (cmd_i.key_rd && !key_last) begin
        idx_q <= idx_q + AddrW'(1);
      end
    end
  end

  // Result register; key bytes come straight from the buffer's read register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (act == hbp_pkg::ACT_ONE || act == hbp_pkg::ACT_TWO)) begin
      kind_q     <= res_kind;
      byte_q     <= res_byte;
      last_q     <= (act == hbp_pkg::ACT_ONE);
      from_ram_q <= 1'b0;
      oerr_q     <= err_q;
      ofold_q    <= fold_d;
      oovf_q     <= ovf_q;
    end else if (cmd_i.load_blk) begin
      kind_q     <= hbp_pkg::KIND_BLK_END;
      byte_q     <= '0;
      last_q     <= 1'b1;
      from_ram_q <= 1'b0;
    end else if (cmd_i.key_rd) begin
      kind_q     <= hbp_pkg::KIND_KEY;
      byte_q     <= '0;
      last_q     <= key_last;
      from_ram_q <= 1'b1;
      oerr_q     <= err_q;
      ofold_q    <= fold_q;
      oovf_q     <= ovf_q;
    end
  end

  hbp_ram #(
    .Width (8),
    .Depth (KeyCap)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && wr_en),
    .waddr_i (wr_addr),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.key_rd),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign status_o.act      = act;
  assign status_o.out_last = last_q;

  assign out_kind_o     = kind_q;
  assign out_byte_o     = from_ram_q ? ram_rdata : byte_q;
  assign last_o         = last_q;
  assign had_errors_o   = oerr_q;
  assign had_folding_o  = ofold_q;
  assign key_overflow_o = oovf_q;

endmodule

### hdl/hbp_controller.sv
// Controller of the header block parser: handshakes and result sequencing.
`timescale 1ns / 1ps

module hbp_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  hbp_pkg::dp_status_t status_i,
  output hbp_pkg::dp_cmd_t    cmd_o
);

  hbp_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbp_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      hbp_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          case (status_i.act)
            hbp_pkg::ACT_ONE:  state_d = hbp_pkg::CS_OUT;
            hbp_pkg::ACT_TWO:  state_d = hbp_pkg::CS_HDR_OUT;
            hbp_pkg::ACT_KEYS: state_d = hbp_pkg::CS_KEY_RD;
            default:           state_d = hbp_pkg::CS_IDLE;
          endcase
        end
      end
      hbp_pkg::CS_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = hbp_pkg::CS_IDLE;
        end
      end
      hbp_pkg::CS_HDR_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.load_blk = 1'b1;
          state_d        = hbp_pkg::CS_OUT;
        end
      end
      hbp_pkg::CS_KEY_RD: begin
        cmd_o.key_rd = 1'b1;
        state_d      = hbp_pkg::CS_KEY_OUT;
      end
      hbp_pkg::CS_KEY_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = status_i.out_last ? hbp_pkg::CS_IDLE : hbp_pkg::CS_KEY_RD;
        end
      end
      default: begin
        state_d = hbp_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

### hdl/header_block_parser_core.sv
// Top level of the header block parser: controller, datapath and checks.
`timescale 1ns / 1ps

// The parser takes a mail or HTTP style header block one byte per input item
// and turns it into a tagged stream of result items: key bytes, value bytes,
// a header end marker after each header and a block end marker after the
// empty line that closes the block. CR is ignored, NUL and malformed lines
// raise the sticky error flag, keys longer than the key buffer are cut and
// flagged, and folded continuation lines are kept and flagged. Every result
// carries the three sticky flags as they stand when it is made, and last
// marks the final result of each input byte. The block handles one input
// item at a time. The colon that ends a key is taken first; then each key
// byte is read from the key buffer RAM, whose read data is registered, and
// is shown on the output before the next one is read. After the block end
// marker every byte is taken and dropped until reset. No clearing pass runs
// after reset; the key buffer holds min(KEY_DEPTH, 32) bytes.

module header_block_parser_core #(
  parameter int unsigned KEY_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       had_errors_o,
  output logic       had_folding_o,
  output logic       key_overflow_o
);

  // Keys are buffered up to the parameter depth, never beyond what one item may emit.
  localparam int unsigned KeyCap =
      (KEY_DEPTH < hbp_pkg::MaxResults) ? KEY_DEPTH : hbp_pkg::MaxResults;

  hbp_pkg::dp_cmd_t    cmd;
  hbp_pkg::dp_status_t status;

  // The controller owns the handshakes and walks through multi-result items.
  hbp_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath decodes each byte, keeps the parse state and the key buffer,
  // and holds the result item shown on the output.
  hbp_datapath #(
    .KeyCap (KeyCap)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o),
    .had_errors_o   (had_errors_o),
    .had_folding_o  (had_folding_o),
    .key_overflow_o (key_overflow_o)
  );

`ifndef SYNTHESIS
  // Input is never taken while a result of the previous item is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // Once the last result of an item is taken the block is ready for the next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("not ready after the last result of an item");

  // More results follow a result that is not the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_ready_i && !last_o) |=> !in_ready_o)
    else $error("input taken before all results of an item were sent");

  // Markers carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (out_kind_o == hbp_pkg::KIND_HDR_END ||
                       out_kind_o == hbp_pkg::KIND_BLK_END)) |-> (out_byte_o == 8'h00))
    else $error("marker with nonzero byte");

  // The block end marker always closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_kind_o == hbp_pkg::KIND_BLK_END) |-> last_o)
    else $error("block end marker not marked last");
`endif

endmodule

### tb/tb_header_block_parser_core.sv
// Self-checking testbench for header_block_parser_core with its own parser predictor.
`timescale 1ns / 1ps

// The testbench feeds one header block to the parser, a byte per input item,
// and checks every result item against a predictor that parses the same bytes.
// Reset is applied once, so the whole run is one block. The block end marker
// can only appear once, at the very end. The stimulus has three parts:
//   - A directed table that walks through the line-start errors, the broken
//     keys, blank handling in values, CR, NUL, a folded line and the colon
//     that follows a line break. Rows whose result is obvious carry it typed
//     in, and the other rows take theirs from the predictor.
//   - Random headers with random content, and short bursts of noise biased
//     toward the special bytes. The first random key is longer than the key
//     buffer, so truncation and a full 32-result key drain are always seen.
//   - A closing sequence that reaches the block end marker, and then a few
//     bytes that the parser must swallow without any result.
// Both handshakes see random gaps and random back pressure.
module tb_header_block_parser_core;

  localparam int unsigned KeyDepth    = 32;
  localparam int unsigned KeyCap      =
      (KeyDepth < hbp_pkg::MaxResults) ? KeyDepth : hbp_pkg::MaxResults;
  localparam int          RandItems   = 70;
  localparam int          StallLimit  = 4000;
  localparam int          DrainCycles = 2 * hbp_pkg::MaxResults + 20;

  // One result item as the parser reports it.
  typedef struct packed {
    hbp_pkg::out_kind_e kind;
    logic [7:0]         data;
    logic               last;
    logic               err;
    logic               fold;
    logic               ovf;
  } hdr_result_t;

  // One row of the directed table. A typed row carries its expected result
  // (none or exactly one); any other row is checked against the predictor.
  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic        has_res;
    hdr_result_t res;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       had_errors_o;
  logic       had_folding_o;
  logic       key_overflow_o;

  header_block_parser_core #(
    .KEY_DEPTH(KeyDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .had_errors_o  (had_errors_o),
    .had_folding_o (had_folding_o),
    .key_overflow_o(key_overflow_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: the parser as it stands after every accepted byte.
  hbp_pkg::parse_state_e ps = hbp_pkg::PS_INITIAL;
  logic [7:0]   key_buf [hbp_pkg::MaxResults];
  int unsigned  key_len = 0;
  logic         val_started = 1'b0;
  logic         err_flag = 1'b0;
  logic         fold_flag = 1'b0;
  logic         ovf_flag = 1'b0;

  // Results of the byte being predicted, before last is marked.
  hdr_result_t  step_res [hbp_pkg::MaxResults];
  int           step_n;

  hdr_result_t  result_q [$];
  stim_row_t    directed_rows [$];

  int mismatches = 0;
  int items_in = 0;
  int rand_items = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int in_calm = 0;
  int out_calm = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void emit_result(input hbp_pkg::out_kind_e kind,
                                      input logic [7:0] data);
    hdr_result_t r;
    if (step_n >= hbp_pkg::MaxResults) return;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    r.err  = err_flag;
    r.fold = fold_flag;
    r.ovf  = ovf_flag;
    step_res[step_n] = r;
    step_n++;
  endfunction

  // Key bytes beyond the buffer are dropped, and the overflow flag records it.
  function automatic void keep_key_byte(input logic [7:0] b);
    if (key_len < KeyCap) begin
      key_buf[key_len] = b;
      key_len++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  function automatic void close_header();
    emit_result(hbp_pkg::KIND_HDR_END, 8'h00);
    key_len = 0;
    val_started = 1'b0;
  endfunction

  // Advances the predictor by one byte and leaves its results in step_res.
  function automatic void parse_byte(input logic [7:0] b);
    int i;
    step_n = 0;
    if (ps == hbp_pkg::PS_FINAL) return;
    case (b)
      hbp_pkg::ChNul: err_flag = 1'b1;
      hbp_pkg::ChCr: ;
      hbp_pkg::ChLf: begin
        case (ps)
          hbp_pkg::PS_INITIAL: begin
            emit_result(hbp_pkg::KIND_BLK_END, 8'h00);
            ps = hbp_pkg::PS_FINAL;
          end
          hbp_pkg::PS_KEY: begin
            err_flag = 1'b1;
            key_len = 0;
            ps = hbp_pkg::PS_INITIAL;
          end
          hbp_pkg::PS_VALUE: ps = hbp_pkg::PS_NEWLINE;
          hbp_pkg::PS_NEWLINE: begin
            close_header();
            emit_result(hbp_pkg::KIND_BLK_END, 8'h00);
            ps = hbp_pkg::PS_FINAL;
          end
          default: begin
            key_len = 0;
            ps = hbp_pkg::PS_INITIAL;
          end
        endcase
      end
      hbp_pkg::ChSpace, hbp_pkg::ChTab: begin
        case (ps)
          hbp_pkg::PS_INITIAL, hbp_pkg::PS_KEY: begin
            key_len = 0;
            err_flag = 1'b1;
            ps = hbp_pkg::PS_ERROR;
          end
          hbp_pkg::PS_VALUE: if (val_started) emit_result(hbp_pkg::KIND_VALUE, b);
          hbp_pkg::PS_NEWLINE: begin
            fold_flag = 1'b1;
            ps = hbp_pkg::PS_VALUE;
            if (val_started) emit_result(hbp_pkg::KIND_VALUE, b);
          end
          default: ;
        endcase
      end
      hbp_pkg::ChColon: begin
        case (ps)
          hbp_pkg::PS_INITIAL: begin
            err_flag = 1'b1;
            ps = hbp_pkg::PS_ERROR;
          end
          hbp_pkg::PS_KEY: begin
            for (i = 0; i < key_len; i++) emit_result(hbp_pkg::KIND_KEY, key_buf[i]);
            key_len = 0;
            val_started = 1'b0;
            ps = hbp_pkg::PS_VALUE;
          end
          hbp_pkg::PS_VALUE: begin
            emit_result(hbp_pkg::KIND_VALUE, b);
            val_started = 1'b1;
          end
          hbp_pkg::PS_NEWLINE: begin
            close_header();
            err_flag = 1'b1;
            ps = hbp_pkg::PS_ERROR;
          end
          default: ;
        endcase
      end
      default: begin
        case (ps)
          hbp_pkg::PS_INITIAL: begin
            keep_key_byte(b);
            ps = hbp_pkg::PS_KEY;
          end
          hbp_pkg::PS_KEY: keep_key_byte(b);
          hbp_pkg::PS_VALUE: begin
            emit_result(hbp_pkg::KIND_VALUE, b);
            val_started = 1'b1;
          end
          hbp_pkg::PS_NEWLINE: begin
            close_header();
            keep_key_byte(b);
            ps = hbp_pkg::PS_KEY;
          end
          default: ;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Gap length in cycles: mostly none or short, now and then long. A calm
  // stretch hands out zero gaps for a while so that full-rate runs occur too.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void plan(input logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.b = b;
    directed_rows.push_back(row);
  endfunction

  function automatic void plan_none(input logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.b = b;
    row.typed = 1'b1;
    directed_rows.push_back(row);
  endfunction

  function automatic void plan_one(input logic [7:0] b, input hbp_pkg::out_kind_e kind,
                                   input logic [7:0] data, input logic err,
                                   input logic fold);
    stim_row_t row;
    row = '0;
    row.b = b;
    row.typed = 1'b1;
    row.has_res = 1'b1;
    row.res.kind = kind;
    row.res.data = data;
    row.res.last = 1'b1;
    row.res.err = err;
    row.res.fold = fold;
    directed_rows.push_back(row);
  endfunction

  // Any byte that is not one of the parser's special characters.
  function automatic logic [7:0] token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == hbp_pkg::ChNul || b == hbp_pkg::ChTab || b == hbp_pkg::ChLf ||
           b == hbp_pkg::ChCr || b == hbp_pkg::ChSpace || b == hbp_pkg::ChColon);
    return b;
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == hbp_pkg::ChNul || b == hbp_pkg::ChLf);
    return b;
  endfunction

  // Noise leans on the special characters to break sequences in odd places.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 11))
      0: return hbp_pkg::ChNul;
      1: return hbp_pkg::ChTab;
      2: return hbp_pkg::ChLf;
      3: return hbp_pkg::ChCr;
      4: return hbp_pkg::ChSpace;
      5: return hbp_pkg::ChColon;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Presents one item, waits for it to be taken and records what it should
  // cause: the typed result for a typed row, the predictor's results otherwise.
  // The predictor is always advanced, so its state stays in step either way.
  task automatic drive_byte(input logic [7:0] b, input logic typed, input logic has_res,
                            input hdr_result_t typed_res);
    int gap;
    int i;
    hdr_result_t r;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_in++;
    parse_byte(b);
    if (typed) begin
      if (has_res) result_q.push_back(typed_res);
    end else begin
      for (i = 0; i < step_n; i++) begin
        r = step_res[i];
        r.last = (i == step_n - 1);
        result_q.push_back(r);
      end
    end
  endtask

  // Random bytes must not close the block early: an LF at the start of a
  // line would end it, so that one is turned into an ordinary key byte.
  task automatic send_rand(input logic [7:0] b);
    if (b == hbp_pkg::ChLf && (ps == hbp_pkg::PS_INITIAL || ps == hbp_pkg::PS_NEWLINE)) begin
      b = 8'h61;
    end
    if (ps != hbp_pkg::PS_ERROR && b != hbp_pkg::ChCr) rand_items++;
    drive_byte(b, 1'b0, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: back pressure, result checking and the watchdog
  // ---------------------------------------------------------------------------

  initial begin : out_ready_gen
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      n = pick_gap(out_calm);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : out_check
    hdr_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("result with nothing expected: kind %0d, byte 0x%02h", out_kind_o,
                 out_byte_o);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("out_kind", 32'(want.kind), 32'(out_kind_o));
          check_field("out_byte", 32'(want.data), 32'(out_byte_o));
          check_field("last", 32'(want.last), 32'(last_o));
          check_field("had_errors", 32'(want.err), 32'(had_errors_o));
          check_field("had_folding", 32'(want.fold), 32'(had_folding_o));
          check_field("key_overflow", 32'(want.ovf), 32'(key_overflow_o));
        end
      end
      // The watchdog only counts cycles in which neither side moves an item.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 < StallLimit) begin
        quiet_cycles <= quiet_cycles + 1;
      end else begin
        $display("Watchdog: %0d cycles without a transfer, %0d results still expected",
                 StallLimit, result_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int          n;
    int          r;
    logic        long_key;
    logic        long_done;
    stim_row_t   row;

    long_done = 1'b0;

    // Directed table. The comments give the parser state before each byte.
    plan_none(hbp_pkg::ChCr);                 // initial: CR is ignored
    plan_none(hbp_pkg::ChNul);                // NUL only raises the error flag
    plan_none(hbp_pkg::ChColon);              // colon at line start: skip line
    plan_none(hbp_pkg::ChLf);                 // error: back to line start
    plan_none(8'hFF);                         // key starts, top byte value
    plan_none(8'h01);
    plan_none(hbp_pkg::ChSpace);              // blank inside a key drops it
    plan_none(hbp_pkg::ChLf);
    plan_none(8'h4B);
    plan_none(hbp_pkg::ChLf);                 // LF inside a key drops it
    plan_none(hbp_pkg::ChTab);                // blank at line start
    plan_none(hbp_pkg::ChLf);
    plan(8'h48);
    plan(8'h7F);
    plan(hbp_pkg::ChColon);                   // key drains: two key bytes
    plan_none(hbp_pkg::ChSpace);              // leading blanks are dropped
    plan_none(hbp_pkg::ChTab);
    plan_one(8'h01, hbp_pkg::KIND_VALUE, 8'h01, 1'b1, 1'b0);
    plan(hbp_pkg::ChSpace);                   // inner blank is kept
    plan(hbp_pkg::ChColon);                   // colon inside a value is data
    plan_none(hbp_pkg::ChCr);
    plan_none(hbp_pkg::ChLf);                 // value: line break pending
    // The folded line keeps its blank.
    plan_one(hbp_pkg::ChTab, hbp_pkg::KIND_VALUE, 8'h09, 1'b1, 1'b1);
    plan_one(8'hFF, hbp_pkg::KIND_VALUE, 8'hFF, 1'b1, 1'b1);
    plan_none(hbp_pkg::ChLf);
    // A colon after a line break closes the header, then skips the line.
    plan_one(hbp_pkg::ChColon, hbp_pkg::KIND_HDR_END, 8'h00, 1'b1, 1'b1);
    plan_none(hbp_pkg::ChLf);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      drive_byte(row.b, row.typed, row.has_res, row.res);
    end

    // Random part: mostly well-formed headers with random content, some of
    // them folded, mixed with short noise bursts. The first pass is always a
    // header, started from the line start that the directed table leaves.
    while (rand_items < RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 75 || !long_done) begin
        long_key = !long_done || ($urandom_range(0, 9) == 0);
        long_done = 1'b1;
        n = long_key ? $urandom_range(KeyCap + 1, KeyCap + 8) : $urandom_range(1, 10);
        repeat (n) send_rand(token_byte());
        send_rand(hbp_pkg::ChColon);
        repeat ($urandom_range(0, 2)) begin
          send_rand($urandom_range(0, 1) ? hbp_pkg::ChSpace : hbp_pkg::ChTab);
        end
        repeat ($urandom_range(0, 12)) send_rand(value_byte());
        if ($urandom_range(0, 1)) send_rand(hbp_pkg::ChCr);
        send_rand(hbp_pkg::ChLf);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            send_rand($urandom_range(0, 1) ? hbp_pkg::ChSpace : hbp_pkg::ChTab);
          end
          repeat ($urandom_range(1, 8)) send_rand(value_byte());
          send_rand(hbp_pkg::ChLf);
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_rand(noise_byte());
      end
    end

    // Close the block from wherever the parser stands: a pending key is ended
    // by its colon, and every other state reaches the end with line breaks.
    while (ps != hbp_pkg::PS_FINAL) begin
      if (ps == hbp_pkg::PS_KEY) drive_byte(hbp_pkg::ChColon, 1'b0, 1'b0, '0);
      else drive_byte(hbp_pkg::ChLf, 1'b0, 1'b0, '0);
    end

    // After the block end marker every byte must vanish without a result.
    drive_byte(hbp_pkg::ChNul, 1'b0, 1'b0, '0);
    drive_byte(hbp_pkg::ChLf, 1'b0, 1'b0, '0);
    repeat (3) drive_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d input bytes (%0d random) and %0d checked results.",
             items_in, rand_items, results_seen);
    $display("Flags at the end: errors %0b, folding %0b, key overflow %0b.",
             err_flag, fold_flag, ovf_flag);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
